/* rtl/core/qsc_pkg.sv */
// Package for the quad scissor clipper: operation codes, widths, state
// encoding and shared request types. No dependencies.
package qsc_pkg;

  localparam int CoordW = 16;
  localparam int TexW = 18;
  localparam int StackDepthDef = 16;
  localparam int ScreenWDef = 640;
  localparam int ScreenHDef = 480;

  // Numerator of the rounded quotient: 2*(b-a)*num + den, up to about 40 bits.
  localparam int NumW = 56;
  localparam int DenW = 18;
  localparam int QuoW = 40;

  typedef enum logic [1:0] {
    OP_CLIP = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_TRIM,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_POP_RD,
    ST_POP_LD,
    ST_DIV_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  // Request to the serial divider.
  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic        [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [QuoW-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [CoordW-1:0] sat16(input logic signed [19:0] v);
    logic signed [19:0] hi;
    logic signed [19:0] lo;
    hi = 20'sd32767;
    lo = -20'sd32768;
    if (v > hi) return 16'sh7fff;
    if (v < lo) return 16'sh8000;
    return v[CoordW-1:0];
  endfunction

endpackage

/* rtl/core/quad_scissor_clipper_with_rect_stack.sv */
// Quad scissor clipper with a stack of clip rectangles.
// Top level; depends on qsc_pkg, qsc_rect_stack, qsc_serial_div.
//
// One request is handled at a time. A quad fully inside, or a set clipping
// request that keeps the current value, goes from EVAL straight to DONE; a
// trimmed quad without texcoords or a culled quad passes through TRIM; pop
// and disable pass through POP_RD and POP_LD; push and enable pass through
// PUSH_RD, PUSH_WR and POP_LD. A trimmed quad with texcoords runs four
// fractions through one bit-serial divider, one quotient bit per cycle over
// 56 bits; each fraction passes a multiply step, a start step and a wait for
// the divider, and that divider sets the rate. The stack lives in a RAM with
// a registered read, so push and pop spend a state fetching the top entry.
// No clearing pass is needed after reset. The result register holds a
// finished result until it is taken; the next request is accepted from the
// edge after it has been taken.
module quad_scissor_clipper_with_rect_stack #(
  parameter int StackDepth = qsc_pkg::StackDepthDef,
  parameter int ScreenW = qsc_pkg::ScreenWDef,
  parameter int ScreenH = qsc_pkg::ScreenHDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] size_w,
  input  logic signed [15:0] size_h,
  input  logic signed [17:0] tex_s_left,
  input  logic signed [17:0] tex_t_top,
  input  logic signed [17:0] tex_s_right,
  input  logic signed [17:0] tex_t_bottom,
  input  logic        has_texcoords,
  input  logic        enable_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_h,
  output logic signed [17:0] out_s_left,
  output logic signed [17:0] out_t_top,
  output logic signed [17:0] out_s_right,
  output logic signed [17:0] out_t_bottom,
  output logic        culled,
  output logic        stack_overflow
);

  localparam int CW = qsc_pkg::CoordW;
  localparam int CntW = $clog2(StackDepth + 1);
  // Screen extents in Q12.4, and the widened bounds, saturated to 16 bits.
  localparam int ScrWq = (ScreenW * 16 > 32767) ? 32767 : ScreenW * 16;
  localparam int ScrHq = (ScreenH * 16 > 32767) ? 32767 : ScreenH * 16;
  localparam int WideR = (ScreenW * 32 > 32767) ? 32767 : ScreenW * 32;
  localparam int WideB = (ScreenH * 32 > 32767) ? 32767 : ScreenH * 32;
  localparam int WideL = (ScreenW * 16 > 32768) ? -32768 : -(ScreenW * 16);
  localparam int WideT = (ScreenH * 16 > 32768) ? -32768 : -(ScreenH * 16);

  qsc_pkg::state_t state, state_next;

  // Latched request
  qsc_pkg::op_t op;
  logic signed [CW-1:0] ox, oy, ow, oh;
  logic signed [17:0] s1, t1, s2, t2;
  logic tex;
  logic en;

  // Clip bounds and stack control
  logic signed [CW-1:0] bl, bt, br, bb;
  logic [CntW-1:0] count;
  logic clip_on;

  // Trim working values (wide enough to avoid overflow)
  logic signed [19:0] x, y, w, h;
  logic fully_in;

  // Result register
  logic signed [CW-1:0] rx, ry, rw, rh;
  logic signed [17:0] rs1, rt1, rs2, rt2;
  logic rcull, rovf;
  logic rvalid;

  // Stack RAM
  logic st_we;
  logic [CntW-1:0] st_waddr, st_raddr;
  logic [4*CW-1:0] st_wdata, st_rdata;

  // Divider
  qsc_pkg::div_req_t dreq;
  qsc_pkg::div_rsp_t drsp;
  logic [1:0] frac_idx;

  // Push pending: rect and whether to widen afterward
  logic signed [19:0] px, py, pr, pb;
  logic widen;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != qsc_pkg::ST_IDLE) || rvalid;

  qsc_rect_stack #(.StackDepth(StackDepth)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qsc_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Top entry fields from RAM read data
  logic signed [CW-1:0] tl, tt, tr, tb;
  assign tl = st_rdata[4*CW-1:3*CW];
  assign tt = st_rdata[3*CW-1:2*CW];
  assign tr = st_rdata[2*CW-1:CW];
  assign tb = st_rdata[CW-1:0];

  // Parent rectangle for a push: screen when empty.
  logic signed [19:0] parl, part, parr, parb;
  logic signed [19:0] nl, nt, nr, nb, ir, ib;
  always_comb begin
    if (count == '0) begin
      parl = '0;
      part = '0;
      parr = 20'(ScrWq);
      parb = 20'(ScrHq);
    end else begin
      parl = 20'(tl);
      part = 20'(tt);
      parr = 20'(tr);
      parb = 20'(tb);
    end
    nl = (parl > px) ? parl : px;
    nt = (part > py) ? part : py;
    ir = (parr < pr) ? parr : pr;
    ib = (parb < pb) ? parb : pb;
    nr = (ir > nl) ? ir : nl;
    nb = (ib > nt) ? ib : nt;
  end

  assign st_raddr = (count == '0) ? '0 : count - CntW'(1);
  assign st_waddr = count;
  assign st_we = (state == qsc_pkg::ST_PUSH_WR) && (count < CntW'(StackDepth));
  assign st_wdata = {nl[CW-1:0], nt[CW-1:0], nr[CW-1:0], nb[CW-1:0]};

  // Divider numerator for fraction frac_idx: 2*(b-a)*num + den
  logic signed [18:0] diff;
  logic signed [19:0] fnum;
  logic signed [CW-1:0] fden;
  logic signed [17:0] fbase;
  always_comb begin
    case (frac_idx)
      2'd0: begin
        diff = 19'(s2) - 19'(s1); fnum = x - 20'(ox); fden = ow; fbase = s1;
      end
      2'd1: begin
        diff = 19'(t2) - 19'(t1); fnum = y - 20'(oy); fden = oh; fbase = t1;
      end
      2'd2: begin
        diff = 19'(s2) - 19'(s1); fnum = x + w - 20'(ox); fden = ow; fbase = s1;
      end
      default: begin
        diff = 19'(t2) - 19'(t1); fnum = y + h - 20'(oy); fden = oh; fbase = t1;
      end
    endcase
  end

  // 19 x 20 product, registered in the multiply cycle ahead of the divider start.
  logic signed [38:0] mul;
  assign mul = diff * fnum;

  logic signed [qsc_pkg::NumW-1:0] prod;
  always_ff @(posedge clk) begin
    prod <= qsc_pkg::NumW'(mul);
  end

  // Divisor is twice the original extent so the quotient rounds half up.
  always_comb begin
    dreq.start = (state == qsc_pkg::ST_DIV_GO);
    dreq.num = (prod <<< 1) + qsc_pkg::NumW'(fden);
    dreq.den = qsc_pkg::DenW'({fden, 1'b0});
  end

  logic signed [17:0] lerp_res;
  assign lerp_res = (fden <= 0) ? fbase : fbase + drsp.quo[17:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      qsc_pkg::ST_IDLE: if (accept) state_next = qsc_pkg::ST_EVAL;
      qsc_pkg::ST_EVAL: begin
        unique case (op)
          qsc_pkg::OP_CLIP: state_next = fully_in ? qsc_pkg::ST_DONE : qsc_pkg::ST_TRIM;
          qsc_pkg::OP_PUSH: state_next = qsc_pkg::ST_PUSH_RD;
          qsc_pkg::OP_POP:  state_next = qsc_pkg::ST_POP_RD;
          default: begin
            if (en == clip_on) state_next = qsc_pkg::ST_DONE;
            else if (en) state_next = qsc_pkg::ST_PUSH_RD;
            else state_next = qsc_pkg::ST_POP_RD;
          end
        endcase
      end
      qsc_pkg::ST_TRIM:
        state_next = (!tcull && tex) ? qsc_pkg::ST_DIV_MUL : qsc_pkg::ST_DONE;
      qsc_pkg::ST_PUSH_RD: state_next = qsc_pkg::ST_PUSH_WR;
      qsc_pkg::ST_PUSH_WR: state_next = qsc_pkg::ST_POP_LD;
      qsc_pkg::ST_POP_RD: state_next = qsc_pkg::ST_POP_LD;
      qsc_pkg::ST_POP_LD: state_next = qsc_pkg::ST_DONE;
      qsc_pkg::ST_DIV_MUL: state_next = qsc_pkg::ST_DIV_GO;
      qsc_pkg::ST_DIV_GO: state_next = qsc_pkg::ST_DIV_WAIT;
      qsc_pkg::ST_DIV_WAIT:
        if (drsp.done) begin
          state_next = (frac_idx == 2'd3) ? qsc_pkg::ST_DONE : qsc_pkg::ST_DIV_MUL;
        end
      default: state_next = qsc_pkg::ST_IDLE;
    endcase
  end

  // Quad fully inside test on latched request
  always_comb begin
    fully_in = (ox >= bl) && (oy >= bt) && (20'(ox) + 20'(ow) <= 20'(br))
            && (20'(oy) + 20'(oh) <= 20'(bb));
  end

  // Trim combinational (from latched quad)
  logic signed [19:0] tx, ty, tw, th;
  logic tcull;
  always_comb begin
    tx = 20'(ox); ty = 20'(oy); tw = 20'(ow); th = 20'(oh);
    tcull = 1'b0;
    if (ox < bl) begin
      tw = tw - (20'(bl) - 20'(ox)); tx = 20'(bl);
    end else if (ox > br) tcull = 1'b1;
    if (oy < bt) begin
      th = th - (20'(bt) - 20'(oy)); ty = 20'(bt);
    end else if (oy > bb) tcull = 1'b1;
    if (!tcull) begin
      if (tx + tw > 20'(br)) tw = 20'(br) - tx;
      if (ty + th > 20'(bb)) th = 20'(bb) - ty;
      if (tw <= 0 || th <= 0) tcull = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsc_pkg::ST_IDLE;
      bl <= '0;
      bt <= '0;
      br <= CW'(ScrWq);
      bb <= CW'(ScrHq);
      count <= '0;
      clip_on <= 1'b0;
      rvalid <= 1'b0;
      frac_idx <= '0;
    end else begin
      state <= state_next;
      if (rvalid && !out_stall) rvalid <= 1'b0;
      unique case (state)
        qsc_pkg::ST_IDLE: if (accept) begin
          op <= qsc_pkg::op_t'(operation);
          ox <= pos_x; oy <= pos_y; ow <= size_w; oh <= size_h;
          s1 <= tex_s_left; t1 <= tex_t_top; s2 <= tex_s_right; t2 <= tex_t_bottom;
          tex <= has_texcoords;
          en <= enable_value;
          rx <= '0; ry <= '0; rw <= '0; rh <= '0;
          rs1 <= '0; rt1 <= '0; rs2 <= '0; rt2 <= '0;
          rcull <= 1'b0; rovf <= 1'b0;
          frac_idx <= '0;
        end
        qsc_pkg::ST_EVAL: begin
          if (op == qsc_pkg::OP_CLIP && fully_in) begin
            rx <= ox; ry <= oy; rw <= ow; rh <= oh;
            if (tex) begin
              rs1 <= s1; rt1 <= t1; rs2 <= s2; rt2 <= t2;
            end
          end
          if (op == qsc_pkg::OP_PUSH) begin
            px <= 20'(ox); py <= 20'(oy);
            pr <= 20'(ox) + 20'(ow); pb <= 20'(oy) + 20'(oh);
            widen <= 1'b0;
          end else begin
            px <= '0; py <= '0; pr <= 20'(ScrWq); pb <= 20'(ScrHq);
            widen <= 1'b1;
          end
          if (op == qsc_pkg::OP_SET && en != clip_on) clip_on <= en;
          if (op == qsc_pkg::OP_POP || (op == qsc_pkg::OP_SET && !en && clip_on))
            if (count != '0) count <= count - CntW'(1);
          if (op == qsc_pkg::OP_SET && en == clip_on) begin
            rx <= bl; ry <= bt; rw <= br; rh <= bb;
          end
        end
        qsc_pkg::ST_TRIM: begin
          x <= tx; y <= ty; w <= tw; h <= th;
          rcull <= tcull;
          if (!tcull) begin
            rx <= tx[CW-1:0]; ry <= ty[CW-1:0];
            rw <= qsc_pkg::sat16(tw); rh <= qsc_pkg::sat16(th);
          end
        end
        qsc_pkg::ST_PUSH_WR: begin
          // new entry becomes the bounds; a refused push leaves them alone
          if (count < CntW'(StackDepth)) begin
            count <= count + CntW'(1);
            bl <= nl[CW-1:0]; bt <= nt[CW-1:0]; br <= nr[CW-1:0]; bb <= nb[CW-1:0];
          end else rovf <= 1'b1;
        end
        qsc_pkg::ST_POP_LD: begin
          // st_rdata holds the top after count settled (read issued last cycle)
          if (widen && op == qsc_pkg::OP_SET && en) begin
            bl <= CW'(WideL); bt <= CW'(WideT); br <= CW'(WideR); bb <= CW'(WideB);
            rx <= CW'(WideL); ry <= CW'(WideT); rw <= CW'(WideR); rh <= CW'(WideB);
          end else if (op == qsc_pkg::OP_PUSH) begin
            rx <= bl; ry <= bt; rw <= br; rh <= bb;
          end else if (count == '0) begin
            bl <= '0; bt <= '0; br <= CW'(ScrWq); bb <= CW'(ScrHq);
            rx <= '0; ry <= '0; rw <= CW'(ScrWq); rh <= CW'(ScrHq);
          end else begin
            bl <= tl; bt <= tt; br <= tr; bb <= tb;
            rx <= tl; ry <= tt; rw <= tr; rh <= tb;
          end
        end
        qsc_pkg::ST_DIV_WAIT: if (drsp.done) begin
          case (frac_idx)
            2'd0: rs1 <= lerp_res;
            2'd1: rt1 <= lerp_res;
            2'd2: rs2 <= lerp_res;
            default: rt2 <= lerp_res;
          endcase
          frac_idx <= frac_idx + 2'd1;
        end
        qsc_pkg::ST_DONE: rvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = rvalid;
  assign out_x = rx;
  assign out_y = ry;
  assign out_w = rw;
  assign out_h = rh;
  assign out_s_left = rs1;
  assign out_t_top = rt1;
  assign out_s_right = rs2;
  assign out_t_bottom = rt2;
  assign culled = rcull;
  assign stack_overflow = rovf;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(StackDepth)) else $error("stack count out of range");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != qsc_pkg::ST_IDLE |-> in_stall) else $error("accepted while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == qsc_pkg::ST_DONE |=> rvalid) else $error("result not posted");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> !(rcull && rovf)) else $error("cull and overflow together");

endmodule

/* rtl/core/qsc_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, rounds toward
// minus infinity (floor) for a positive divisor. Depends on qsc_pkg.
module qsc_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  qsc_pkg::div_req_t req,
  output qsc_pkg::div_rsp_t rsp
);

  localparam int NW = qsc_pkg::NumW;
  localparam int DW = qsc_pkg::DenW;
  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0] dividend;
  logic [DW:0]   rem;
  logic [DW-1:0] den;
  logic          neg;
  logic [CntW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [DW+1:0] trial;
  logic [DW+1:0] sub;
  logic          fits;

  always_comb begin
    trial = {rem, dividend[NW-1]};
    sub = trial - {2'b00, den};
    fits = !sub[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CntW'(NW);
        neg <= req.num[NW-1];
        // floor of negative n: -((-n + d - 1) / d)
        dividend <= req.num[NW-1] ? NW'(-req.num + NW'(req.den) - NW'(1)) : req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        dividend <= {dividend[NW-2:0], fits};
        rem <= fits ? sub[DW:0] : trial[DW:0];
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = neg ? -$signed(dividend[qsc_pkg::QuoW-1:0])
                       : $signed(dividend[qsc_pkg::QuoW-1:0]);

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !rsp.done |=> busy || done) else $error("divider dropped work");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider busy at done");

endmodule

/* rtl/core/qsc_rect_stack.sv */
// Clip rectangle stack memory, one write and one registered read port.
// Depends on qsc_pkg.
module qsc_rect_stack #(
  parameter int StackDepth = qsc_pkg::StackDepthDef
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(StackDepth+1)-1:0] waddr,
  input  logic [4*qsc_pkg::CoordW-1:0]  wdata,
  input  logic [$clog2(StackDepth+1)-1:0] raddr,
  output logic [4*qsc_pkg::CoordW-1:0]  rdata
);

  localparam int AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  logic [4*qsc_pkg::CoordW-1:0] mem [StackDepth];
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  always_comb begin
    wa = AW'(waddr);
    ra = AW'(raddr);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wdata;
    rdata <= mem[ra];
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for quad_scissor_clipper_with_rect_stack: directed table plus
// random requests, scored against an in-bench scissor/stack predictor.
// Depends on qsc_pkg and the clipper RTL.
module tb;

  localparam int ScrW = 640 * 16;
  localparam int ScrH = 480 * 16;
  localparam int Depth = 16;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [1:0] op;
    logic signed [15:0] x, y, w, h;
    logic signed [17:0] s1, t1, s2, t2;
    logic tex, en;
  } req_t;

  typedef struct packed {
    logic signed [15:0] x, y, w, h;
    logic signed [17:0] sl, tt, sr, tb;
    logic cull, ovf;
  } res_t;

  // One directed row: the request and, when chk is set, the literal result.
  typedef struct {
    req_t rq;
    bit chk;
    res_t rs;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] operation = qsc_pkg::OP_CLIP;
  logic signed [15:0] pos_x = '0, pos_y = '0, size_w = '0, size_h = '0;
  logic signed [17:0] tex_s_left = '0, tex_t_top = '0, tex_s_right = '0, tex_t_bottom = '0;
  logic has_texcoords = 1'b0, enable_value = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic signed [15:0] out_x, out_y, out_w, out_h;
  logic signed [17:0] out_s_left, out_t_top, out_s_right, out_t_bottom;
  logic culled, stack_overflow;

  always #5 clk = ~clk;

  quad_scissor_clipper_with_rect_stack dut (.*);

  // Predictor state: clip bounds, rectangle stack and the enable flag.
  int bl, bt, br, bb;
  int stk_l[Depth], stk_t[Depth], stk_r[Depth], stk_b[Depth];
  int depth_n;
  bit clip_en;
  res_t pending[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_recv = 0;

  function automatic int sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void load_top();
    if (depth_n > 0) begin
      bl = stk_l[depth_n-1]; bt = stk_t[depth_n-1];
      br = stk_r[depth_n-1]; bb = stk_b[depth_n-1];
    end else begin
      bl = 0; bt = 0; br = ScrW; bb = ScrH;
    end
  endfunction

  function automatic bit push_rect(int x, int y, int w, int h);
    int pl, pt, pr, pb, nl, nt;
    if (depth_n >= Depth) return 1;
    if (depth_n == 0) begin
      pl = 0; pt = 0; pr = ScrW; pb = ScrH;
    end else begin
      pl = stk_l[depth_n-1]; pt = stk_t[depth_n-1];
      pr = stk_r[depth_n-1]; pb = stk_b[depth_n-1];
    end
    nl = pl > x ? pl : x;
    nt = pt > y ? pt : y;
    stk_l[depth_n] = nl; stk_t[depth_n] = nt;
    stk_r[depth_n] = (pr < x + w ? pr : x + w); if (stk_r[depth_n] < nl) stk_r[depth_n] = nl;
    stk_b[depth_n] = (pb < y + h ? pb : y + h); if (stk_b[depth_n] < nt) stk_b[depth_n] = nt;
    depth_n++;
    load_top();
    return 0;
  endfunction

  function automatic void pop_rect();
    if (depth_n > 0) depth_n--;
    load_top();
  endfunction

  // a + (b-a)*num/den, quotient rounded half toward +inf
  function automatic int blend(int a, int b, int num, int den);
    longint n, d, q;
    if (den <= 0) return a;
    n = 2 * longint'(b - a) * longint'(num) + den;
    d = 2 * longint'(den);
    if (n >= 0) q = n / d;
    else q = -((-n + d - 1) / d);
    return int'(longint'(a) + q);
  endfunction

  function automatic res_t scissor(req_t q);
    res_t r;
    int ox, oy, ow, oh, x, y, w, h;
    int s1, t1, s2, t2;
    bit cull;
    r = '0;
    ox = int'(q.x); oy = int'(q.y); ow = int'(q.w); oh = int'(q.h);
    s1 = int'(q.s1); t1 = int'(q.t1); s2 = int'(q.s2); t2 = int'(q.t2);
    x = ox; y = oy; w = ow; h = oh; cull = 0;
    if (q.op == qsc_pkg::OP_CLIP) begin
      if (ox >= bl && oy >= bt && ox + ow <= br && oy + oh <= bb) begin
        r.x = q.x; r.y = q.y; r.w = q.w; r.h = q.h;
        if (q.tex) begin
          r.sl = q.s1; r.tt = q.t1; r.sr = q.s2; r.tb = q.t2;
        end
      end else begin
        if (ox < bl) begin w -= bl - ox; x = bl; end
        else if (ox > br) cull = 1;
        if (oy < bt) begin h -= bt - oy; y = bt; end
        else if (oy > bb) cull = 1;
        if (!cull) begin
          if (x + w > br) w = br - x;
          if (y + h > bb) h = bb - y;
          if (w <= 0 || h <= 0) cull = 1;
        end
        if (cull) r.cull = 1'b1;
        else begin
          r.x = 16'(x); r.y = 16'(y); r.w = 16'(sat(w)); r.h = 16'(sat(h));
          if (q.tex) begin
            r.sl = 18'(blend(s1, s2, x - ox, ow));
            r.sr = 18'(blend(s1, s2, x + w - ox, ow));
            r.tt = 18'(blend(t1, t2, y - oy, oh));
            r.tb = 18'(blend(t1, t2, y + h - oy, oh));
          end
        end
      end
    end else begin
      if (q.op == qsc_pkg::OP_PUSH) r.ovf = push_rect(ox, oy, ow, oh);
      else if (q.op == qsc_pkg::OP_POP) pop_rect();
      else if (q.en != clip_en) begin
        clip_en = q.en;
        if (!q.en) pop_rect();
        else begin
          r.ovf = push_rect(0, 0, ScrW, ScrH);
          bl = -ScrW; br = sat(2 * ScrW); bt = -ScrH; bb = sat(2 * ScrH);
        end
      end
      r.x = 16'(bl); r.y = 16'(bt); r.w = 16'(br); r.h = 16'(bb);
    end
    return r;
  endfunction

  task automatic offer(req_t q);
    operation <= q.op; pos_x <= q.x; pos_y <= q.y; size_w <= q.w; size_h <= q.h;
    tex_s_left <= q.s1; tex_t_top <= q.t1; tex_s_right <= q.s2; tex_t_bottom <= q.t2;
    has_texcoords <= q.tex; enable_value <= q.en;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(scissor(q));
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // Random quad: mostly near the screen so trimming happens, some raw values.
  function automatic req_t rand_req(bit stack_heavy);
    req_t q;
    int k;
    q = '0;
    k = $urandom_range(99);
    if (stack_heavy) begin
      if (k < 40) q.op = qsc_pkg::OP_CLIP;
      else if (k < 70) q.op = qsc_pkg::OP_PUSH;
      else if (k < 90) q.op = qsc_pkg::OP_POP;
      else q.op = qsc_pkg::OP_SET;
    end else begin
      if (k < 70) q.op = qsc_pkg::OP_CLIP;
      else if (k < 82) q.op = qsc_pkg::OP_PUSH;
      else if (k < 94) q.op = qsc_pkg::OP_POP;
      else q.op = qsc_pkg::OP_SET;
    end
    if ($urandom_range(9) == 0) begin
      q.x = 16'($urandom); q.y = 16'($urandom); q.w = 16'($urandom); q.h = 16'($urandom);
    end else begin
      q.x = 16'($signed($urandom_range(0, 13000)) - 1500);
      q.y = 16'($signed($urandom_range(0, 10000)) - 1500);
      q.w = 16'($signed($urandom_range(0, 6000)) - 200);
      q.h = 16'($signed($urandom_range(0, 5000)) - 200);
    end
    q.s1 = 18'($urandom); q.t1 = 18'($urandom); q.s2 = 18'($urandom); q.t2 = 18'($urandom);
    // texcoord quads are slow; keep them to a fraction
    q.tex = $urandom_range(3) == 0;
    q.en = 1'($urandom_range(1));
    return q;
  endfunction

  // Scoreboard: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_x !== e.x) begin $error("out_x exp %0d got %0d", e.x, out_x); errors++; end
        if (out_y !== e.y) begin $error("out_y exp %0d got %0d", e.y, out_y); errors++; end
        if (out_w !== e.w) begin $error("out_w exp %0d got %0d", e.w, out_w); errors++; end
        if (out_h !== e.h) begin $error("out_h exp %0d got %0d", e.h, out_h); errors++; end
        if (out_s_left !== e.sl) begin
          $error("out_s_left exp %0d got %0d", e.sl, out_s_left); errors++;
        end
        if (out_t_top !== e.tt) begin
          $error("out_t_top exp %0d got %0d", e.tt, out_t_top); errors++;
        end
        if (out_s_right !== e.sr) begin
          $error("out_s_right exp %0d got %0d", e.sr, out_s_right); errors++;
        end
        if (out_t_bottom !== e.tb) begin
          $error("out_t_bottom exp %0d got %0d", e.tb, out_t_bottom); errors++;
        end
        if (culled !== e.cull) begin
          $error("culled exp %0d got %0d", e.cull, culled); errors++;
        end
        if (stack_overflow !== e.ovf) begin
          $error("stack_overflow exp %0d got %0d", e.ovf, stack_overflow); errors++;
        end
      end
    end
  end

  // Receiver stall: random per phase, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= recv_stall > 0 && $urandom_range(99) < recv_stall;
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic row_t mk(logic [1:0] op, int x, int y, int w, int h, bit tex, bit en);
    row_t r;
    r.rq = '0;
    r.rq.op = op; r.rq.x = 16'(x); r.rq.y = 16'(y); r.rq.w = 16'(w); r.rq.h = 16'(h);
    r.rq.tex = tex; r.rq.en = en;
    r.rq.s1 = 18'sh00000; r.rq.s2 = 18'sh10000; r.rq.t1 = 18'sh1ffff; r.rq.t2 = 18'sh20000;
    r.chk = 0; r.rs = '0;
    return r;
  endfunction

  function automatic res_t bounds(int l, int t, int r, int b, bit ovf);
    res_t x;
    x = '0; x.x = 16'(l); x.y = 16'(t); x.w = 16'(r); x.h = 16'(b); x.ovf = ovf;
    return x;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    req_t q;
    depth_n = 0; clip_en = 0; load_top();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    rw = mk(qsc_pkg::OP_POP, 0, 0, 0, 0, 0, 0); rw.chk = 1;
    rw.rs = bounds(0, 0, ScrW, ScrH, 0);
    rows.push_back(rw);                                           // pop on empty stack
    rw = mk(qsc_pkg::OP_CLIP, 16, 16, 160, 160, 1, 0); rw.chk = 1;  // fully inside
    rw.rs = bounds(16, 16, 160, 160, 0);
    rw.rs.sl = rw.rq.s1; rw.rs.tt = rw.rq.t1; rw.rs.sr = rw.rq.s2; rw.rs.tb = rw.rq.t2;
    rows.push_back(rw);
    rw = mk(qsc_pkg::OP_CLIP, ScrW + 1, 0, 16, 16, 1, 0); rw.chk = 1; // past right edge
    rw.rs = '0; rw.rs.cull = 1'b1; rows.push_back(rw);
    rw = mk(qsc_pkg::OP_CLIP, 0, ScrH + 1, 16, 16, 0, 0); rw.chk = 1; // past bottom
    rw.rs = '0; rw.rs.cull = 1'b1; rows.push_back(rw);
    rows.push_back(mk(qsc_pkg::OP_CLIP, -32768, -32768, 32767, 32767, 1, 0)); // culled after trim
    rows.push_back(mk(qsc_pkg::OP_CLIP, -100, -100, 400, 300, 1, 0));  // trimmed, texcoords
    rows.push_back(mk(qsc_pkg::OP_CLIP, -100, 10, 50, 50, 1, 0));      // no width left after trim
    rows.push_back(mk(qsc_pkg::OP_CLIP, 32767, 32767, -32768, -32768, 0, 0));
    rows.push_back(mk(qsc_pkg::OP_CLIP, 10000, 7000, 1000, 1000, 0, 0)); // trimmed, no tex
    rw = mk(qsc_pkg::OP_PUSH, 160, 160, 320, 320, 0, 0); rw.chk = 1;
    rw.rs = bounds(160, 160, 480, 480, 0); rows.push_back(rw);
    rw = mk(qsc_pkg::OP_PUSH, 600, 600, 10, 10, 0, 0); rw.chk = 1;    // empty intersection
    rw.rs = bounds(600, 600, 600, 600, 0); rows.push_back(rw);
    rows.push_back(mk(qsc_pkg::OP_CLIP, 170, 170, 100, 100, 1, 0));
    rows.push_back(mk(qsc_pkg::OP_POP, 0, 0, 0, 0, 0, 0));
    rw = mk(qsc_pkg::OP_SET, 0, 0, 0, 0, 0, 1); rw.chk = 1;           // enable widens
    rw.rs = bounds(-ScrW, -ScrH, 2 * ScrW, 2 * ScrH, 0); rows.push_back(rw);
    rows.push_back(mk(qsc_pkg::OP_SET, 0, 0, 0, 0, 0, 1));            // same value
    rows.push_back(mk(qsc_pkg::OP_CLIP, -20000, -20000, 32767, 32767, 1, 0));
    rows.push_back(mk(qsc_pkg::OP_SET, 0, 0, 0, 0, 0, 0));            // disable pops
    for (int i = 0; i < 17; i++) begin
      rows.push_back(mk(qsc_pkg::OP_PUSH, -32768, -32768, 32767, 32767, 0, 0));
    end
    rows.push_back(mk(qsc_pkg::OP_SET, 0, 0, 0, 0, 0, 1));            // enable on full stack
    rows.push_back(mk(qsc_pkg::OP_SET, 0, 0, 0, 0, 0, 0));

    foreach (rows[i]) begin
      offer(rows[i].rq);
      if (rows[i].chk) begin
        // typed-in literal replaces the predicted value for this row
        void'(pending.pop_back());
        pending.push_back(rows[i].rs);
      end
    end
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 61 : 18) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 61 : 18) : 0;
      for (int i = 0; i < 440; i++) begin
        q = rand_req(ph[0]);
        offer(q);
      end
      // sender pauses until all results are back
      drain();
    end

    // Long receiver hold-off while requests keep coming.
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 140; i++) begin
        q = rand_req(1);
        q.tex = 1'b0;
        offer(q);
      end
    join
    drain();
    repeat (300) @(posedge clk);

    if (errors == 0 && pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
